/* design/pps_pkg.sv */
// Package for the preemptive priority scheduler: field widths, register map,
// slot table entry layout and the state machine types.
// No dependencies.
package pps_pkg;

  // Default size of the process slot table.
  localparam int MAX_PROCESSES_DEF = 16;

  // Field widths of the words on the two channels.
  localparam int SLOT_W  = 4;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 12;
  localparam int PRI_W   = 8;
  localparam int TIME_W  = 17;
  localparam int CFG_W   = 5;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_PROCESS_COUNT = 3'h0;

  // Time counter saturates here.
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // One slot of the process table as held in memory.
  typedef struct packed {
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] rem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // What the previous tick served.
  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_IDLE,
    LAST_SLOT
  } last_t;

endpackage

/* design/pps_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler: top level with configuration port, scan controller
// and result register. Depends on pps_pkg and pps_ram.
// A load word is accepted in the idle state and gives no result. A tick word scans
// the active slots, one slot per cycle read through the single read port of the slot
// memory; when every slot is done it skips the scan and goes straight to its result.
// Reset clears control state and the time counter and marks every slot done; the
// slot memory is not cleared.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pps_pkg::APB_AW-1:0] paddr,
  input  logic [pps_pkg::APB_DW-1:0] pwdata,
  output logic [pps_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [pps_pkg::SLOT_W-1:0] slot,
  input  logic [pps_pkg::ARR_W-1:0]  arrival,
  input  logic [pps_pkg::BURST_W-1:0] burst,
  input  logic [pps_pkg::PRI_W-1:0]  priority_req,
  // Output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pps_pkg::SLOT_W-1:0] running_slot,
  output logic                       idle,
  output logic [pps_pkg::TIME_W-1:0] tick_start,
  output logic                       segment_start,
  output logic                       finished,
  output logic [pps_pkg::TIME_W-1:0] completion_time,
  output logic [pps_pkg::TIME_W-1:0] turnaround,
  output logic [pps_pkg::TIME_W-1:0] waiting,
  output logic                       all_done
);

  import pps_pkg::*;

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SL_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PROCESSES);
  localparam logic [SL_W-1:0]  MAX_SL  = SL_W'(MAX_PROCESSES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCESSES);

  // True when every slot below cnt is flagged done.
  function automatic logic all_taken(input logic [MAX_PROCESSES-1:0] flags,
                                     input logic [CNT_W-1:0] cnt);
    logic r;
    r = 1'b1;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if (!flags[i] && (CNT_W'(i) < cnt)) begin
        r = 1'b0;
      end
    end
    return r;
  endfunction

  state_t                  state, state_next;
  logic [CFG_W-1:0]        process_count;
  logic [CMP_W-1:0]        pc_ext;
  logic [CNT_W-1:0]        act_cnt;
  logic [MAX_PROCESSES-1:0] done_flags;
  logic [MAX_PROCESSES-1:0] done_after;
  logic [TIME_W-1:0]       now_tick;
  logic [TIME_W-1:0]       now_inc;
  last_t                   last_kind;
  logic [IDX_W-1:0]        last_idx;

  logic [CNT_W-1:0]        issue_cnt;
  logic                    issue_more;
  logic                    rd_pend;
  logic [IDX_W-1:0]        rd_idx;
  logic                    found;
  logic [IDX_W-1:0]        best_idx;
  entry_t                  best_ent;
  logic                    tk_all;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;
  entry_t                  rd_ent;

  logic                    apb_wr;
  logic                    reg_hit;
  logic                    in_fire;
  logic                    ld_fire;
  logic                    ld_ok;
  logic [SL_W-1:0]         slot_ext;
  logic [IDX_W-1:0]        ld_addr;
  logic                    cand_ok;
  logic                    cand_better;
  logic                    res_fire;
  logic                    serve;
  logic                    serve_fin;
  logic [TIME_W-1:0]       tat;
  logic [TIME_W-1:0]       wt;
  logic [SL_W-1:0]         best_ext;

  logic [SLOT_W-1:0]       r_run;
  logic                    r_idle;
  logic                    r_seg;
  logic                    r_fin;
  logic [TIME_W-1:0]       r_comp;
  logic [TIME_W-1:0]       r_tat;
  logic [TIME_W-1:0]       r_wt;
  logic                    r_all;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == ADDR_PROCESS_COUNT[APB_AW-1:2]);
  assign apb_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_hit ? APB_DW'(process_count) : '0;

  // Slots taking part, clipped to the table size.
  assign pc_ext  = CMP_W'(process_count);
  assign act_cnt = (pc_ext > MAX_CMP) ? MAX_CNT : pc_ext[CNT_W-1:0];

  // Input handshake and load decode.
  assign in_fire  = in_valid && in_ready;
  assign ld_fire  = in_fire && (cmd == CMD_LOAD);
  assign slot_ext = SL_W'(slot);
  assign ld_ok    = (slot_ext < MAX_SL);
  assign ld_addr  = slot_ext[IDX_W-1:0];

  // Scan: one read issued per cycle, evaluated when its data returns.
  assign issue_more = (state == ST_SCAN) && (issue_cnt < act_cnt);
  assign ram_raddr  = issue_cnt[IDX_W-1:0];
  assign rd_ent     = entry_t'(ram_rdata);
  assign cand_ok    = rd_pend && !done_flags[rd_idx] &&
                      (TIME_W'(rd_ent.arr) <= now_tick);
  assign cand_better = !found || (rd_ent.pri < best_ent.pri) ||
                       ((rd_ent.pri == best_ent.pri) && (rd_ent.arr < best_ent.arr));

  // Tick result arithmetic for the chosen slot.
  assign res_fire  = (state == ST_FINISH) && (!out_valid || out_ready);
  assign serve     = !tk_all && found;
  assign serve_fin = (best_ent.rem <= BURST_W'(1));
  assign now_inc   = (now_tick == TIME_MAX) ? now_tick : now_tick + TIME_W'(1);
  assign tat       = now_inc - TIME_W'(best_ent.arr);
  assign wt        = (tat > TIME_W'(best_ent.burst)) ? tat - TIME_W'(best_ent.burst) : '0;
  assign best_ext  = SL_W'(best_idx);

  // Done flags as they stand after this tick.
  always_comb begin
    done_after = done_flags;
    if (serve && serve_fin) begin
      done_after[best_idx] = 1'b1;
    end
  end

  // Result word fields.
  always_comb begin
    r_run  = '0;
    r_idle = 1'b1;
    r_seg  = 1'b0;
    r_fin  = 1'b0;
    r_comp = '0;
    r_tat  = '0;
    r_wt   = '0;
    r_all  = all_taken(done_after, act_cnt);
    if (tk_all) begin
      r_all = 1'b1;
    end else if (!found) begin
      r_seg = (last_kind != LAST_IDLE);
    end else begin
      r_idle = 1'b0;
      r_run  = best_ext[SLOT_W-1:0];
      r_seg  = !((last_kind == LAST_SLOT) && (last_idx == best_idx));
      if (serve_fin) begin
        r_fin  = 1'b1;
        r_comp = now_inc;
        r_tat  = tat;
        r_wt   = wt;
      end
    end
  end

  // Memory write: a load fills a slot, a served tick writes back its remaining time.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ld_addr;
    ram_wdata = '{arr: arrival, burst: burst, pri: priority_req, rem: burst};
    if (ld_fire && ld_ok) begin
      ram_we = 1'b1;
    end else if (res_fire && serve) begin
      ram_we        = 1'b1;
      ram_waddr     = best_idx;
      ram_wdata     = best_ent;
      ram_wdata.rem = serve_fin ? '0 : best_ent.rem - BURST_W'(1);
    end
  end

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCESSES),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state and input ready.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && (cmd == CMD_TICK)) begin
          state_next = all_taken(done_flags, act_cnt) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_more && !rd_pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      process_count <= '0;
      done_flags    <= '1;
      now_tick      <= '0;
      last_kind     <= LAST_NONE;
      last_idx      <= '0;
      issue_cnt     <= '0;
      rd_pend       <= 1'b0;
      rd_idx        <= '0;
      found         <= 1'b0;
      best_idx      <= '0;
      tk_all        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (apb_wr && reg_hit) begin
        process_count <= pwdata[CFG_W-1:0];
      end

      // A load restarts the schedule.
      if (ld_fire && ld_ok) begin
        done_flags[ld_addr] <= 1'b0;
        now_tick            <= '0;
        last_kind           <= LAST_NONE;
      end

      // Start of a tick.
      if (in_fire && (cmd == CMD_TICK)) begin
        issue_cnt <= '0;
        rd_pend   <= 1'b0;
        found     <= 1'b0;
        tk_all    <= all_taken(done_flags, act_cnt);
      end

      // Slot scan.
      if (state == ST_SCAN) begin
        rd_pend <= issue_more;
        if (issue_more) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
          rd_idx    <= issue_cnt[IDX_W-1:0];
        end
        if (cand_ok && cand_better) begin
          found    <= 1'b1;
          best_idx <= rd_idx;
        end
      end

      // Commit the tick.
      if (res_fire && !tk_all) begin
        now_tick <= now_inc;
        if (!found) begin
          last_kind <= LAST_IDLE;
        end else if (serve_fin) begin
          last_kind            <= LAST_NONE;
          done_flags[best_idx] <= 1'b1;
        end else begin
          last_kind <= LAST_SLOT;
          last_idx  <= best_idx;
        end
      end

      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Best candidate contents and result word.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && cand_ok && cand_better) begin
      best_ent <= rd_ent;
    end
    if (res_fire) begin
      running_slot    <= r_run;
      idle            <= r_idle;
      tick_start      <= now_tick;
      segment_start   <= r_seg;
      finished        <= r_fin;
      completion_time <= r_comp;
      turnaround      <= r_tat;
      waiting         <= r_wt;
      all_done        <= r_all;
    end
  end

  // A completing tick leaves its slot marked done.
  a_finish_marks_done: assert property (@(posedge clk) disable iff (rst)
    (res_fire && serve && serve_fin) |=> done_flags[$past(best_idx)])
    else $error("completed slot not marked done");

  // A completion is never reported on an idle tick.
  a_finish_not_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> !idle)
    else $error("finished result reported as idle");

  // The slot memory is not written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !ram_we)
    else $error("slot memory written during scan");

  // Once every slot is done, a tick leaves time where it was.
  a_all_done_holds_time: assert property (@(posedge clk) disable iff (rst)
    (res_fire && tk_all) |=> $stable(now_tick))
    else $error("time advanced after all slots were done");

endmodule

/* test/preemptive_priority_scheduler_tb.sv */
// Self-checking testbench for the preemptive priority scheduler: a directed table
// of load and tick words, then random scheduling scenarios, checked against an in-bench
// scheduler or a row's typed result. Depends on pps_pkg and the preemptive_priority_scheduler RTL.
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int SLOTS          = MAX_PROCESSES_DEF;
  localparam int RANDOM_WORDS   = 1600;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  // One tick result as it appears on the output channel.
  typedef struct packed {
    logic [SLOT_W-1:0] run_slot;
    logic              idle;
    logic [TIME_W-1:0] start;
    logic              seg;
    logic              fin;
    logic [TIME_W-1:0] comp;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_time;
    logic              all_done;
  } tick_report_t;

  typedef enum logic {ROW_WORD, ROW_SET_COUNT} plan_kind_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    plan_kind_t         kind;
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
    logic [CFG_W-1:0]   count;
    bit                 typed;
    tick_report_t       want;
  } plan_row_t;

  localparam tick_report_t NOT_TYPED = '0;
  localparam tick_report_t ALL_DONE_AT_ZERO = '{idle: 1'b1, all_done: 1'b1, default: '0};
  // Slot 0 with a zero burst runs once and completes at time 1.
  localparam tick_report_t SLOT0_ONE_SHOT =
    '{seg: 1'b1, fin: 1'b1, comp: 17'd1, tat: 17'd1, wait_time: 17'd1, default: '0};

  localparam logic [CFG_W-1:0] COUNT_SWEEP [7] = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd17, 5'd5, 5'd2};

  // Directed words: empty table, zero burst, field extremes, priority and
  // arrival ties, preemption, a load while running and a clipped waiting time.
  plan_row_t directed_plan [25] = '{
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b1, ALL_DONE_AT_ZERO},
    '{ROW_WORD, CMD_LOAD, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b1, ALL_DONE_AT_ZERO},
    '{ROW_SET_COUNT, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd31, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd15, 16'hFFFF, 12'hFFF, 8'hFF, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b1, SLOT0_ONE_SHOT},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd3, 16'd2, 12'd3, 8'd5, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd4, 16'd0, 12'd2, 8'd5, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd5, 16'd0, 12'd1, 8'd5, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd6, 16'd1, 12'd2, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_LOAD, 4'd7, 16'd0, 12'd1, 8'd200, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED},
    '{ROW_WORD, CMD_TICK, 4'd0, 16'd0, 12'd0, 8'd0, 5'd0, 1'b0, NOT_TYPED}
  };

  logic                clk;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                cmd          = CMD_LOAD;
  logic [SLOT_W-1:0]   slot         = '0;
  logic [ARR_W-1:0]    arrival      = '0;
  logic [BURST_W-1:0]  burst        = '0;
  logic [PRI_W-1:0]    priority_req = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [SLOT_W-1:0]   running_slot;
  logic                idle;
  logic [TIME_W-1:0]   tick_start;
  logic                segment_start;
  logic                finished;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround;
  logic [TIME_W-1:0]   waiting;
  logic                all_done;

  // Scheduler state mirrored in the bench.
  logic [ARR_W-1:0]   arr_tab   [SLOTS];
  logic [BURST_W-1:0] burst_tab [SLOTS];
  logic [PRI_W-1:0]   pri_tab   [SLOTS];
  logic [BURST_W-1:0] rem_tab   [SLOTS];
  bit                 done_tab  [SLOTS];
  logic [TIME_W-1:0]  sched_now;
  last_t              last_kind;
  int                 last_slot;
  logic [CFG_W-1:0]   sched_count;

  tick_report_t expected_reports [$];
  int unsigned  mismatch_count = 0;
  int unsigned  words_sent     = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_idle_pct  = 0;

  preemptive_priority_scheduler DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .cmd, .slot, .arrival, .burst, .priority_req,
    .out_valid, .out_ready, .running_slot, .idle, .tick_start, .segment_start,
    .finished, .completion_time, .turnaround, .waiting, .all_done
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic string show_report(input tick_report_t r);
    return $sformatf({"slot=%0d idle=%0b start=%0d seg=%0b fin=%0b ",
                      "comp=%0d tat=%0d wait=%0d all=%0b"},
                     r.run_slot, r.idle, r.start, r.seg, r.fin, r.comp, r.tat, r.wait_time,
                     r.all_done);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic bit slots_all_done(input int n);
    for (int i = 0; i < n; i++) begin
      if (!done_tab[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A load rewrites one slot and restarts the schedule clock.
  function automatic void apply_load(input logic [SLOT_W-1:0] s, input logic [ARR_W-1:0] a,
                                     input logic [BURST_W-1:0] b, input logic [PRI_W-1:0] p);
    arr_tab[s]   = a;
    burst_tab[s] = b;
    pri_tab[s]   = p;
    rem_tab[s]   = b;
    done_tab[s]  = 1'b0;
    sched_now    = '0;
    last_kind    = LAST_NONE;
  endfunction

  // Serve one tick: lowest priority value, then earliest arrival, then lowest slot.
  function automatic tick_report_t predict_tick();
    tick_report_t      r;
    int                n;
    int                best;
    bit                found;
    logic [TIME_W-1:0] tat;
    r = '0;
    n = (int'(sched_count) > SLOTS) ? SLOTS : int'(sched_count);
    r.start = sched_now;
    if (slots_all_done(n)) begin
      r.idle = 1'b1;
      r.all_done = 1'b1;
      return r;
    end
    found = 1'b0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (done_tab[i] || TIME_W'(arr_tab[i]) > sched_now) continue;
      if (!found || pri_tab[i] < pri_tab[best] ||
          (pri_tab[i] == pri_tab[best] && arr_tab[i] < arr_tab[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (sched_now != TIME_MAX) sched_now = sched_now + 1'b1;
    if (!found) begin
      r.idle = 1'b1;
      r.seg = (last_kind != LAST_IDLE);
      last_kind = LAST_IDLE;
    end else begin
      r.run_slot = SLOT_W'(best);
      r.seg = !(last_kind == LAST_SLOT && last_slot == best);
      last_kind = LAST_SLOT;
      last_slot = best;
      // A zero burst counts as one tick of service.
      if (rem_tab[best] <= 1) begin
        tat = sched_now - TIME_W'(arr_tab[best]);
        r.fin = 1'b1;
        r.comp = sched_now;
        r.tat = tat;
        r.wait_time = (tat > TIME_W'(burst_tab[best])) ? tat - TIME_W'(burst_tab[best]) : '0;
        rem_tab[best] = '0;
        done_tab[best] = 1'b1;
        last_kind = LAST_NONE;
      end else begin
        rem_tab[best] = rem_tab[best] - 1'b1;
      end
    end
    r.all_done = slots_all_done(n);
    return r;
  endfunction

  // Offer one word, hold it until accepted, then update the expected results.
  task automatic push_word(input logic c, input logic [SLOT_W-1:0] s, input logic [ARR_W-1:0] a,
                           input logic [BURST_W-1:0] b, input logic [PRI_W-1:0] p,
                           input bit typed, input tick_report_t want);
    tick_report_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    slot         <= s;
    arrival      <= a;
    burst        <= b;
    priority_req <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (c == CMD_LOAD) begin
      apply_load(s, a, b, p);
    end else begin
      predicted = predict_tick();
      expected_reports.insert(expected_reports.size(), typed ? want : predicted);
    end
  endtask

  // Tick words carry random junk in the unused fields.
  task automatic push_tick();
    push_word(CMD_TICK, SLOT_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
              PRI_W'($urandom), 1'b0, NOT_TYPED);
  endtask

  // Mostly short bursts and early arrivals, with occasional full-range values.
  task automatic load_random(input logic [SLOT_W-1:0] s);
    logic [ARR_W-1:0]   a;
    logic [BURST_W-1:0] b;
    logic [PRI_W-1:0]   p;
    int unsigned        pick;
    a = ($urandom_range(0, 29) == 0) ? ARR_W'($urandom) : ARR_W'($urandom_range(0, 20));
    pick = $urandom_range(0, 39);
    if (pick == 0) b = BURST_W'($urandom);
    else if (pick == 1) b = '0;
    else b = BURST_W'($urandom_range(1, 6));
    p = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
    push_word(CMD_LOAD, s, a, b, p, 1'b0, NOT_TYPED);
  endtask

  // Stop sending, let every result drain, then give any load time to land.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the process count, then read it back.
  task automatic write_count(input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PROCESS_COUNT;
    pwdata  <= {{(APB_DW-CFG_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sched_count = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== value)
      note_mismatch($sformatf("process_count read back: expected %0d got %0d",
                              value, prdata[CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One scenario: set the count, load the taking part slots, then run ticks
  // with the odd load dropped in mid-run.
  task automatic run_scenario(input logic [CFG_W-1:0] count_val);
    int n;
    int ticks;
    settle_block();
    write_count(count_val);
    n = (int'(count_val) > SLOTS) ? SLOTS : int'(count_val);
    for (int s = 0; s < n; s++) load_random(SLOT_W'(s));
    if (n < SLOTS && $urandom_range(0, 2) == 0)
      load_random(SLOT_W'($urandom_range(n, SLOTS - 1)));
    ticks = 4 * n + 6 + int'($urandom_range(0, 8));
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 29) == 0) load_random(SLOT_W'($urandom_range(0, SLOTS - 1)));
      push_tick();
    end
  endtask

  // Receiver: random back-pressure and the result check.
  always @(posedge clk) begin : result_check
    tick_report_t seen;
    tick_report_t wanted;
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      seen = {running_slot, idle, tick_start, segment_start, finished, completion_time,
              turnaround, waiting, all_done};
      if (expected_reports.size() == 0) begin
        note_mismatch({"unexpected result: ", show_report(seen)});
      end else begin
        wanted = expected_reports.pop_front();
        if (seen !== wanted)
          note_mismatch({"result mismatch\n  expected ", show_report(wanted),
                         "\n  actual   ", show_report(seen)});
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned      random_base;
    int               scenario_idx;
    logic [CFG_W-1:0] next_count;
    for (int i = 0; i < SLOTS; i++) begin
      arr_tab[i]   = '0;
      burst_tab[i] = '0;
      pri_tab[i]   = '0;
      rem_tab[i]   = '0;
      done_tab[i]  = 1'b1;
    end
    sched_now   = '0;
    last_kind   = LAST_NONE;
    last_slot   = 0;
    sched_count = '0;
    scenario_idx = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    send_idle_pct = 10;
    recv_idle_pct = 77;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_SET_COUNT) begin
        settle_block();
        write_count(directed_plan[i].count);
      end else begin
        push_word(directed_plan[i].cmd, directed_plan[i].slot, directed_plan[i].arr,
                  directed_plan[i].burst, directed_plan[i].pri, directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    // Random scenarios; idling pattern changes by thirds.
    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      if (words_sent - random_base < RANDOM_WORDS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 77;
      end else if (words_sent - random_base < 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (scenario_idx < 7) next_count = COUNT_SWEEP[scenario_idx];
      else if ($urandom_range(0, 3) == 0) next_count = CFG_W'($urandom_range(0, 31));
      else next_count = CFG_W'($urandom_range(1, 8));
      run_scenario(next_count);
      scenario_idx++;
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* preemptive_priority_scheduler.f */
design/pps_pkg.sv
design/pps_ram.sv
design/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
